[hw/rtl/mam_pkg.sv]
`default_nettype none

package mam_pkg;

    // sizes of the window store and the datapath
    localparam int WINDOW_MAX  = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int CFG_BITS    = 11;
    localparam int PTR_BITS    = $clog2(WINDOW_MAX);
    localparam int LEN_BITS    = PTR_BITS + 1;
    localparam int SUM_BITS    = SAMPLE_BITS + PTR_BITS + 1;
    localparam int MAG_BITS    = SUM_BITS - 1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [SUM_BITS-1:0]    sum_t;
    typedef logic        [LEN_BITS-1:0]    len_t;
    typedef logic        [PTR_BITS-1:0]    ptr_t;

    typedef struct packed {
        sample_t sample;
        logic    last_of_series;
    } in_beat_t;

    typedef struct packed {
        sample_t min_average;
        sample_t max_average;
        logic    window_filled;
    } out_beat_t;

    // handshake between sequencer and divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // widen a sample to running sum width
    function automatic sum_t sext_sample(input sample_t s);
        sum_t r;
        r = {{(SUM_BITS-SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/mam_ram.sv]
`default_nettype none

module mam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/mam_div.sv]
`default_nettype none

module mam_div
    import mam_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire sum_t    dividend,
    input  wire len_t    divisor,
    output div_status_t  status,
    output sample_t      quotient
);

    localparam int CNT_BITS = $clog2(MAG_BITS);

    logic [MAG_BITS-1:0] mag_reg, mag_next;
    len_t                rem_reg, rem_next;
    len_t                div_reg, div_next;
    logic                neg_reg, neg_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic [LEN_BITS:0]    rem_shift;
    logic                 ge;
    sum_t                 abs_dvd;
    logic [SAMPLE_BITS:0] q_mag;
    logic [SAMPLE_BITS:0] q_signed;

    // magnitude of the signed dividend
    assign abs_dvd = dividend[SUM_BITS-1] ? -dividend : dividend;

    // one restoring step per cycle
    assign rem_shift = {rem_reg, mag_reg[MAG_BITS-1]};
    assign ge        = (rem_shift >= {1'b0, div_reg});

    always_comb
    begin
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            mag_next  = abs_dvd[MAG_BITS-1:0];
            rem_next  = '0;
            div_next  = divisor;
            neg_next  = dividend[SUM_BITS-1];
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? LEN_BITS'(rem_shift - {1'b0, div_reg})
                          : rem_shift[LEN_BITS-1:0];
            mag_next = {mag_reg[MAG_BITS-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_BITS'(MAG_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    // truncate toward zero: negate the magnitude quotient
    assign q_mag    = mag_reg[SAMPLE_BITS:0];
    assign q_signed = neg_reg ? -q_mag : q_mag;
    assign quotient = sample_t'(q_signed[SAMPLE_BITS-1:0]);

    assign status.busy = busy_reg;
    assign status.done = done_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
    a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");
`endif

endmodule

`default_nettype wire

[hw/rtl/moving_average_min_max.sv]
// Sliding-window moving average with min/max tracking over a series of samples.
// Input channel in_valid/in_stall/in_data carries one sample beat with a
// last-of-series mark. Output channel out_valid/out_stall/out_data carries one
// result beat per series (least and greatest window average, window_filled).
// cfg_we/cfg_wdata set the window length (0 reads as 1, above 1024 as 1024);
// a write also clears the series in progress. Write only while idle.
// One beat is worked on at a time. A beat that does not complete a window
// passes through the update and finish steps before the next accept; a beat
// with a full window also waits in the divide step for the bit-serial
// divider (one quotient bit per cycle over the 26-bit sum magnitude). The delay
// store is a single-port-write RAM with a registered read, read at accept and
// written back in the following cycle. A result appears in the cycle after its
// last beat finishes. The result register lets the next beat be taken while a
// result waits; when the receiver stalls and a second result is ready, the block
// holds it and stalls input until the first is taken. Reset clears the series
// state and out_valid, sets the window length to 1; no RAM clearing pass.
`default_nettype none

module moving_average_min_max
    import mam_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire in_beat_t            in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output out_beat_t                out_data,
    input  wire logic                cfg_we,
    input  wire logic [CFG_BITS-1:0] cfg_wdata
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_UPDATE = 2'd1;
    localparam logic [1:0] ST_DIVIDE = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg, state_next;
    len_t       len_reg, len_next;
    ptr_t       wp_reg, wp_next;
    sum_t       sum_reg, sum_next;
    len_t       seen_reg, seen_next;
    sample_t    least_reg, least_next;
    sample_t    greatest_reg, greatest_next;
    logic       first_reg, first_next;
    logic       out_valid_reg, out_valid_next;
    out_beat_t  out_data_reg, out_data_next;
    sample_t    sample_reg;
    logic       last_reg;

    logic        in_accept;
    logic        out_free;
    logic        full_before;
    len_t        wp_inc;
    len_t        cfg_len;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic        ram_we;
    logic        div_start;
    div_status_t div_status;
    sample_t     div_quotient;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    // delay store: read the outgoing sample at accept, write the new one next cycle
    mam_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (sample_reg),
        .re    (in_accept),
        .raddr (wp_reg),
        .rdata (rd_data)
    );

    assign ram_we = (state_reg == ST_UPDATE);

    // window average divider
    mam_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (len_reg),
        .status   (div_status),
        .quotient (div_quotient)
    );

    // clamp the written window length
    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            cfg_len = len_t'(1);
        end
        else if (cfg_wdata > CFG_BITS'(WINDOW_MAX))
        begin
            cfg_len = len_t'(WINDOW_MAX);
        end
        else
        begin
            cfg_len = len_t'(cfg_wdata);
        end
    end

    assign full_before = (seen_reg >= len_reg);
    assign wp_inc      = len_t'(wp_reg) + 1'b1;

    // sequencer and series state
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        wp_next        = wp_reg;
        sum_next       = sum_reg;
        seen_next      = seen_reg;
        least_next     = least_reg;
        greatest_next  = greatest_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        div_start      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                sum_next  = sum_reg + sext_sample(sample_reg)
                          - (full_before ? sext_sample(sample_t'(rd_data)) : '0);
                seen_next = full_before ? seen_reg : seen_reg + 1'b1;
                wp_next   = (wp_inc == len_reg) ? '0 : wp_inc[PTR_BITS-1:0];
                first_next = !full_before;
                if (seen_next == len_reg)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIVIDE:
            begin
                if (div_status.done)
                begin
                    if (first_reg)
                    begin
                        least_next    = div_quotient;
                        greatest_next = div_quotient;
                    end
                    else
                    begin
                        if (div_quotient < least_reg)
                        begin
                            least_next = div_quotient;
                        end
                        if (div_quotient > greatest_reg)
                        begin
                            greatest_next = div_quotient;
                        end
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.min_average   = least_reg;
                    out_data_next.max_average   = greatest_reg;
                    out_data_next.window_filled = (seen_reg >= len_reg);
                    wp_next       = '0;
                    sum_next      = '0;
                    seen_next     = '0;
                    least_next    = '0;
                    greatest_next = '0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a length write restarts the series
        if (cfg_we)
        begin
            len_next      = cfg_len;
            wp_next       = '0;
            sum_next      = '0;
            seen_next     = '0;
            least_next    = '0;
            greatest_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= len_t'(1);
            wp_reg        <= '0;
            sum_reg       <= '0;
            seen_reg      <= '0;
            least_reg     <= '0;
            greatest_reg  <= '0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            wp_reg        <= wp_next;
            sum_reg       <= sum_next;
            seen_reg      <= seen_next;
            least_reg     <= least_next;
            greatest_reg  <= greatest_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // beat payload capture
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (in_accept)
        begin
            sample_reg <= in_data.sample;
            last_reg   <= in_data.last_of_series;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_accept_update: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_UPDATE))
        else $error("accepted beat not followed by store update");
    a_wp_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        len_t'(wp_reg) < len_reg)
        else $error("write pointer outside the window");
    a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= len_reg)
        else $error("sample count above window length");
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == ST_DIVIDE))
        else $error("divider result outside the divide step");
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FINISH && $past(last_reg)))
        else $error("result raised outside the end of a series");
`endif

endmodule

`default_nettype wire

[sim/moving_average_min_max_tb.sv]
`timescale 1ns / 100ps

module moving_average_min_max_tb;
    import mam_pkg::*;

    localparam int IDLE_PCT      = 20;
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_BEATS  = 330;
    localparam int MAX_REPORTS   = 10;

    typedef enum logic [1:0] {ITEM_BEAT, ITEM_CFG, ITEM_DRAIN} plan_kind_t;
    typedef enum logic [2:0] {SHAPE_NOISE, SHAPE_NEAR, SHAPE_RAIL, SHAPE_TINY, SHAPE_RAMP}
        sample_shape_t;

    typedef struct {
        plan_kind_t           kind;
        in_beat_t             beat;
        logic [CFG_BITS-1:0]  cfg;
    } plan_item_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    in_beat_t            in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    out_beat_t           out_data;
    logic                cfg_we = 1'b0;
    logic [CFG_BITS-1:0] cfg_wdata = '0;

    int  cycle_no = 0;
    int  quiet_cycles = 0;
    int  fail_count = 0;
    wire calm = ((cycle_no / 1500) % 6) == 3;

    plan_item_t sample_plan[$];
    out_beat_t  expected_extremes[$];

    // window state mirrored from the block
    logic [CFG_BITS-1:0] win_cfg = 1;
    sample_t             win_hist [WINDOW_MAX];
    int                  win_ptr = 0;
    longint              win_sum = 0;
    int                  win_count = 0;
    longint              avg_lo = 0;
    longint              avg_hi = 0;

    moving_average_min_max dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // clock, cycle count advances on the falling edge
    initial
    begin
        forever
        begin
            #4 clk = 1'b1;
            #4 clk = 1'b0;
            cycle_no = cycle_no + 1;
        end
    end

    // length 0 acts as 1, anything above the store depth as the depth
    function automatic int span_of(logic [CFG_BITS-1:0] v);
        if (v == 0)
            return 1;
        if (v > WINDOW_MAX)
            return WINDOW_MAX;
        return int'(v);
    endfunction

    function automatic void clear_series();
        win_ptr   = 0;
        win_sum   = 0;
        win_count = 0;
        avg_lo    = 0;
        avg_hi    = 0;
    endfunction

    // fold one accepted sample into the window, queue a result on the last one
    function automatic void track_window_average(in_beat_t b);
        int        len;
        int        slot;
        longint    avg;
        out_beat_t res;
        len  = span_of(win_cfg);
        slot = (win_ptr >= len) ? 0 : win_ptr;
        if (win_count >= len)
            win_sum -= win_hist[slot];
        win_hist[slot] = b.sample;
        win_sum += b.sample;
        slot++;
        win_ptr = (slot >= len) ? 0 : slot;
        if (win_count < len)
        begin
            win_count++;
            if (win_count == len)
            begin
                avg    = win_sum / len;
                avg_lo = avg;
                avg_hi = avg;
            end
        end
        else
        begin
            avg = win_sum / len;
            if (avg < avg_lo)
                avg_lo = avg;
            if (avg > avg_hi)
                avg_hi = avg;
        end
        if (b.last_of_series)
        begin
            res.min_average   = sample_t'(avg_lo);
            res.max_average   = sample_t'(avg_hi);
            res.window_filled = (win_count >= len);
            expected_extremes = {expected_extremes, res};
            clear_series();
        end
    endfunction

    function automatic void add_beat(int value, logic last);
        plan_item_t it;
        it.kind                = ITEM_BEAT;
        it.beat.sample         = sample_t'(value);
        it.beat.last_of_series = last;
        it.cfg                 = '0;
        sample_plan = {sample_plan, it};
    endfunction

    function automatic void add_cfg(int value);
        plan_item_t it;
        it.kind = ITEM_CFG;
        it.beat = '0;
        it.cfg  = value[CFG_BITS-1:0];
        sample_plan = {sample_plan, it};
    endfunction

    function automatic void add_drain();
        plan_item_t it;
        it.kind = ITEM_DRAIN;
        it.beat = '0;
        it.cfg  = '0;
        sample_plan = {sample_plan, it};
    endfunction

    // one series with a random waveform shape
    function automatic void add_series(int count, logic mark_last);
        sample_shape_t shape;
        int            base;
        int            step;
        int            value;
        shape = sample_shape_t'($urandom_range(0, 4));
        base  = int'($urandom_range(0, 65535)) - 32768;
        step  = int'($urandom_range(0, 200)) - 100;
        for (int i = 0; i < count; i++)
        begin
            case (shape)
                SHAPE_NEAR: value = base + int'($urandom_range(0, 64)) - 32;
                SHAPE_RAIL: value = $urandom_range(0, 1) ? 32767 : -32768;
                SHAPE_TINY: value = int'($urandom_range(0, 14)) - 7;
                SHAPE_RAMP: value = base + i * step;
                default:    value = int'($urandom());
            endcase
            add_beat(value, mark_last && (i == count - 1));
        end
    endfunction

    task automatic report_mismatch(string what, out_beat_t want, out_beat_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t %s: expected %0d %0d %0b, got %0d %0d %0b",
                     $realtime, what, want.min_average, want.max_average, want.window_filled,
                     got.min_average, got.max_average, got.window_filled);
    endtask

    // sender: beats from the plan, window writes only once the block has gone quiet
    always @(posedge clk or negedge rst_n)
    begin : driver
        plan_item_t          head;
        logic                taken;
        logic                next_valid;
        in_beat_t            next_data;
        logic                next_we;
        logic [CFG_BITS-1:0] next_wdata;
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            in_data      <= '0;
            cfg_we       <= 1'b0;
            cfg_wdata    <= '0;
            quiet_cycles = 0;
        end
        else
        begin
            taken      = in_valid && !in_stall;
            next_valid = in_valid && !taken;
            next_data  = in_data;
            next_we    = 1'b0;
            next_wdata = cfg_wdata;
            if (taken)
                track_window_average(in_data);
            if (taken || expected_extremes.size() != 0)
                quiet_cycles = 0;
            else
                quiet_cycles++;

            // a stalled beat stays put, otherwise serve the head of the plan
            if (!next_valid && sample_plan.size() != 0)
            begin
                head = sample_plan[0];
                case (head.kind)
                    ITEM_BEAT:
                        if (calm || $urandom_range(0, 99) >= IDLE_PCT)
                        begin
                            next_valid = 1'b1;
                            next_data  = head.beat;
                            void'(sample_plan.pop_front());
                        end
                    ITEM_CFG:
                        if (quiet_cycles >= SETTLE_CYCLES)
                        begin
                            next_we      = 1'b1;
                            next_wdata   = head.cfg;
                            win_cfg      = head.cfg;
                            clear_series();
                            quiet_cycles = 0;
                            void'(sample_plan.pop_front());
                        end
                    ITEM_DRAIN:
                        if (expected_extremes.size() == 0)
                            void'(sample_plan.pop_front());
                    default: ;
                endcase
            end

            in_valid  <= next_valid;
            in_data   <= next_data;
            cfg_we    <= next_we;
            cfg_wdata <= next_wdata;
        end
    end

    // receiver: random stall, compare each result beat against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin : monitor
        out_beat_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_extremes.size() == 0)
                begin
                    report_mismatch("result with none expected", '0, out_data);
                end
                else
                begin
                    want = expected_extremes.pop_front();
                    if (out_data.min_average !== want.min_average ||
                        out_data.max_average !== want.max_average ||
                        out_data.window_filled !== want.window_filled)
                        report_mismatch("result mismatch", want, out_data);
                end
            end
            out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // stimulus plan, reset and end of run
    initial
    begin
        int width;
        int span;
        int series;
        int count;
        int roll;
        int random_beats;

        // window of one after reset, sample rails
        add_beat(32767, 1'b1);
        add_beat(-32768, 1'b1);
        add_beat(0, 1'b0);
        add_beat(-1, 1'b1);

        // window of three: short series, rails, truncation toward zero
        add_cfg(3);
        add_beat(5, 1'b0);
        add_beat(7, 1'b1);
        add_beat(-32768, 1'b0);
        add_beat(-32768, 1'b0);
        add_beat(-32768, 1'b0);
        add_beat(32767, 1'b0);
        add_beat(32767, 1'b0);
        add_beat(32767, 1'b1);
        add_beat(-7, 1'b0);
        add_beat(2, 1'b0);
        add_beat(0, 1'b1);
        add_drain();

        // length change in the middle of a series, zero length
        add_beat(100, 1'b0);
        add_beat(200, 1'b0);
        add_cfg(0);
        add_beat(-3, 1'b1);

        // all-ones length saturates to the store depth
        add_cfg(2047);
        add_beat(9, 1'b1);
        add_series(WINDOW_MAX + int'($urandom_range(0, 40)), 1'b1);
        add_cfg(WINDOW_MAX);
        add_series(5, 1'b1);

        // random phases, mostly short windows with well-formed series
        random_beats = 0;
        while (random_beats < RANDOM_BEATS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 75)
                width = $urandom_range(1, 8);
            else if (roll < 88)
                width = $urandom_range(9, 48);
            else if (roll < 94)
                width = 0;
            else
                width = $urandom_range(49, 160);
            add_cfg(width);
            span   = span_of(width[CFG_BITS-1:0]);
            series = (span > 48) ? 1 : $urandom_range(1, 6);
            for (int s = 0; s < series; s++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    count = span + $urandom_range(0, 2 * span + 4);
                else if (roll < 90)
                    count = $urandom_range(1, span);
                else
                    count = 1;
                // sometimes the next length write cuts the series short
                add_series(count, !(s == series - 1 && $urandom_range(0, 99) < 15));
                random_beats += count;
                if ($urandom_range(0, 9) == 0)
                    add_drain();
            end
        end
        add_beat(int'($urandom()), 1'b1);

        repeat (11) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (sample_plan.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_extremes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        fail_count += expected_extremes.size();

        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog
    initial
    begin
        #8_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/mam_pkg.sv
hw/rtl/mam_ram.sv
hw/rtl/mam_div.sv
hw/rtl/moving_average_min_max.sv
sim/moving_average_min_max_tb.sv
